@@ hdl/stt_pkg.sv @@
package stt_pkg;

  localparam int unsigned OffsetBits  = 24;
  localparam int unsigned LineBits    = 24;
  localparam int unsigned ColBits     = 16;
  localparam int unsigned KindBits    = 6;
  localparam int unsigned PrefixChars = 8;
  localparam int unsigned NumKeywords = 17;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QPtrBits    = $clog2(QueueDepth);
  localparam int unsigned QCntBits    = $clog2(QueueDepth + 1);

  localparam logic [OffsetBits-1:0] OffMax  = '1;
  localparam logic [LineBits-1:0]   LineMax = '1;
  localparam logic [ColBits-1:0]    ColMax  = '1;

  // configuration register indexes
  localparam logic [1:0] CFG_FIRST_LINE   = 2'd0;
  localparam logic [1:0] CFG_FIRST_COLUMN = 2'd1;

  // token kinds
  localparam logic [KindBits-1:0] KIND_ERROR = 6'd0,  KIND_EOF    = 6'd1;
  localparam logic [KindBits-1:0] KIND_PLUS  = 6'd2,  KIND_MINUS  = 6'd3;
  localparam logic [KindBits-1:0] KIND_STAR  = 6'd4,  KIND_SLASH  = 6'd5;
  localparam logic [KindBits-1:0] KIND_LPAR  = 6'd6,  KIND_RPAR   = 6'd7;
  localparam logic [KindBits-1:0] KIND_LBRK  = 6'd8,  KIND_RBRK   = 6'd9;
  localparam logic [KindBits-1:0] KIND_LBRC  = 6'd10, KIND_RBRC   = 6'd11;
  localparam logic [KindBits-1:0] KIND_AMP   = 6'd12, KIND_PIPE   = 6'd13;
  localparam logic [KindBits-1:0] KIND_CARET = 6'd14, KIND_BANG   = 6'd15;
  localparam logic [KindBits-1:0] KIND_EQ    = 6'd16, KIND_GT     = 6'd17;
  localparam logic [KindBits-1:0] KIND_LT    = 6'd18, KIND_AT     = 6'd19;
  localparam logic [KindBits-1:0] KIND_DOLLAR = 6'd20, KIND_COLON = 6'd21;
  localparam logic [KindBits-1:0] KIND_SEMI  = 6'd22, KIND_COMMA  = 6'd23;
  localparam logic [KindBits-1:0] KIND_ANDAND = 6'd24, KIND_OROR  = 6'd25;
  localparam logic [KindBits-1:0] KIND_EQEQ  = 6'd26, KIND_NE     = 6'd27;
  localparam logic [KindBits-1:0] KIND_GE    = 6'd28, KIND_LE     = 6'd29;
  localparam logic [KindBits-1:0] KIND_SCOPE = 6'd30, KIND_NUMBER = 6'd31;
  localparam logic [KindBits-1:0] KIND_SQSTR = 6'd32, KIND_DQSTR  = 6'd33;
  localparam logic [KindBits-1:0] KIND_IDENT = 6'd34, KIND_KWBASE = 6'd35;

  typedef enum logic [3:0] {
    MODE_IDLE, MODE_HOLD, MODE_SLASH, MODE_LINEC, MODE_BLOCK,
    MODE_BSTAR, MODE_NUM, MODE_WORD, MODE_STR
  } mode_e;

  typedef struct packed {
    logic [KindBits-1:0]   kind;
    logic [OffsetBits-1:0] offset;
    logic [OffsetBits-1:0] length;
    logic [LineBits-1:0]   line;
    logic [ColBits-1:0]    column;
    logic                  last;
  } token_t;

  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  // keywords packed lowest character first
  localparam logic [63:0] KwWord [NumKeywords] = '{
    64'h0000_0073_6169_6c61, 64'h0067_616c_6674_6962, 64'h0000_0000_6574_7962,
    64'h0000_0074_736e_6f63, 64'h0000_0000_6573_6c65, 64'h0000_0000_6d75_6e65,
    64'h0000_6e72_6574_7865, 64'h0000_0000_0000_6e66, 64'h0000_0000_0000_6669,
    64'h0000_6369_6c62_7570, 64'h0000_7463_7572_7473, 64'h0000_006e_6f69_6e75,
    64'h0000_0000_0072_6176, 64'h0000_0000_6469_6f76, 64'h656c_6974_616c_6f76,
    64'h0000_0065_6c69_6877, 64'h0000_0000_6472_6f77
  };
  localparam logic [3:0] KwLen [NumKeywords] = '{
    4'd5, 4'd7, 4'd4, 4'd5, 4'd4, 4'd4, 4'd6, 4'd2, 4'd2,
    4'd6, 4'd6, 4'd5, 4'd3, 4'd4, 4'd8, 4'd5, 4'd4
  };

  function automatic logic [KindBits-1:0] word_kind(logic [63:0] pre,
                                                     logic [OffsetBits-1:0] len);
    logic [KindBits-1:0] k;
    k = KIND_IDENT;
    if (len <= OffsetBits'(PrefixChars)) begin
      for (int i = 0; i < NumKeywords; i++) begin
        if (pre == KwWord[i] && len == OffsetBits'(KwLen[i])) begin
          k = KIND_KWBASE + KindBits'(i);
        end
      end
    end
    return k;
  endfunction

  function automatic logic [KindBits-1:0] single_kind(logic [7:0] c);
    logic [KindBits-1:0] k;
    case (c)
      "+": k = KIND_PLUS;
      "-": k = KIND_MINUS;
      "*": k = KIND_STAR;
      "(": k = KIND_LPAR;
      ")": k = KIND_RPAR;
      "[": k = KIND_LBRK;
      "]": k = KIND_RBRK;
      "{": k = KIND_LBRC;
      "}": k = KIND_RBRC;
      "^": k = KIND_CARET;
      "@": k = KIND_AT;
      "$": k = KIND_DOLLAR;
      ";": k = KIND_SEMI;
      ",": k = KIND_COMMA;
      default: k = KIND_ERROR;
    endcase
    return k;
  endfunction

  function automatic logic [KindBits-1:0] held_single(logic [7:0] h);
    logic [KindBits-1:0] k;
    case (h)
      "&": k = KIND_AMP;
      "|": k = KIND_PIPE;
      "!": k = KIND_BANG;
      "=": k = KIND_EQ;
      ">": k = KIND_GT;
      "<": k = KIND_LT;
      default: k = KIND_COLON;
    endcase
    return k;
  endfunction

  function automatic logic [KindBits-1:0] held_double(logic [7:0] h);
    logic [KindBits-1:0] k;
    case (h)
      "&": k = KIND_ANDAND;
      "|": k = KIND_OROR;
      "!": k = KIND_NE;
      "=": k = KIND_EQEQ;
      ">": k = KIND_GE;
      "<": k = KIND_LE;
      default: k = KIND_SCOPE;
    endcase
    return k;
  endfunction

  function automatic logic is_numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [ColBits-1:0] col_back(logic [OffsetBits-1:0] len,
                                                  logic [ColBits-1:0] col);
    logic [ColBits-1:0] r;
    if (len >= OffsetBits'(col)) r = '0;
    else r = col - len[ColBits-1:0];
    return r;
  endfunction

  function automatic token_t mk_tok(logic [KindBits-1:0] kind, logic [OffsetBits-1:0] off,
                                    logic [OffsetBits-1:0] len, logic [LineBits-1:0] line,
                                    logic [ColBits-1:0] col);
    token_t t;
    t.kind   = kind;
    t.offset = off;
    t.length = len;
    t.line   = line;
    t.column = col;
    t.last   = 1'b0;
    return t;
  endfunction

endpackage

@@ hdl/stt_scan.sv @@
module stt_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     char_code_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [stt_pkg::LineBits-1:0]   cfg_data_i,
  input  logic                           room_i,
  output stt_pkg::push_t                 push_o
);

  stt_pkg::mode_e                  mode_q, mode_d;
  logic [7:0]                      held_q, held_d;
  logic [stt_pkg::OffsetBits-1:0]  off_q, off_d, beg_q, beg_d;
  logic [stt_pkg::LineBits-1:0]    line_q, line_d, fline_q, fline_d;
  logic [stt_pkg::ColBits-1:0]     col_q, col_d, fcol_q, fcol_d;
  logic [63:0]                     pre_q, pre_d;
  logic                            quote_q, quote_d;
  logic                            in_acc, cfg_we, fresh;
  stt_pkg::token_t                 tk0, tk1;
  logic [1:0]                      ntok;

  assign in_stall_o  = !room_i;
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && room_i;
  assign cfg_we      = cfg_valid_i;
  assign fresh       = (mode_q == stt_pkg::MODE_IDLE) && (off_q == '0);

  always_comb begin
    stt_pkg::mode_e                  m;
    logic [7:0]                      c, h, second;
    logic [stt_pkg::OffsetBits-1:0]  off, beg, len;
    logic [stt_pkg::LineBits-1:0]    ln;
    logic [stt_pkg::ColBits-1:0]     cl;
    logic [63:0]                     pre;
    logic                            q, do_start, adv;
    logic [1:0]                      n;
    stt_pkg::token_t                 tk [2];

    m = mode_q; h = held_q; off = off_q; beg = beg_q; ln = line_q; cl = col_q;
    pre = pre_q; q = quote_q; c = char_code_i;
    n = '0; tk[0] = '0; tk[1] = '0; do_start = 1'b0; adv = 1'b0;
    second = "=";
    len = off_q - beg_q;

    case (mode_q)
      stt_pkg::MODE_HOLD: begin
        second = (h == "&" || h == "|" || h == ":") ? h : 8'("=");
        if (c != 8'h00 && c == second) begin
          off = (off != stt_pkg::OffMax) ? off + 1'b1 : off;
          cl  = (cl != stt_pkg::ColMax) ? cl + 1'b1 : cl;
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::held_double(h), beg, 24'd2, ln,
                                     stt_pkg::col_back(24'd2, cl));
          n = n + 1'b1;
          m = stt_pkg::MODE_IDLE;
        end else begin
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::held_single(h), beg, 24'd1, ln,
                                     stt_pkg::col_back(24'd1, cl));
          n = n + 1'b1;
          do_start = 1'b1;
        end
      end
      stt_pkg::MODE_SLASH: begin
        if (c == "/") begin
          adv = 1'b1; m = stt_pkg::MODE_LINEC;
        end else if (c == "*") begin
          adv = 1'b1; m = stt_pkg::MODE_BLOCK;
        end else begin
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::KIND_SLASH, beg, 24'd1, ln,
                                     stt_pkg::col_back(24'd1, cl));
          n = n + 1'b1;
          do_start = 1'b1;
        end
      end
      stt_pkg::MODE_LINEC: begin
        if (c == 8'h00 || c == 8'h0a) do_start = 1'b1;
        else adv = 1'b1;
      end
      stt_pkg::MODE_BLOCK, stt_pkg::MODE_BSTAR: begin
        if (c == 8'h00) begin
          do_start = 1'b1;
        end else if (c == "/" && mode_q == stt_pkg::MODE_BSTAR) begin
          adv = 1'b1; m = stt_pkg::MODE_IDLE;
        end else begin
          if (c == 8'h0a) begin
            ln = (ln != stt_pkg::LineMax) ? ln + 1'b1 : ln;
            cl = '0;
          end
          adv = 1'b1;
          m = (c == "*") ? stt_pkg::MODE_BSTAR : stt_pkg::MODE_BLOCK;
        end
      end
      stt_pkg::MODE_NUM: begin
        if (stt_pkg::is_numeral(c)) begin
          adv = 1'b1;
        end else begin
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::KIND_NUMBER, beg, len, ln,
                                     stt_pkg::col_back(len, cl));
          n = n + 1'b1;
          do_start = 1'b1;
        end
      end
      stt_pkg::MODE_WORD: begin
        if (stt_pkg::is_letter(c) || stt_pkg::is_numeral(c) || c == "_") begin
          if (len < stt_pkg::OffsetBits'(stt_pkg::PrefixChars)) pre[len[2:0]*8 +: 8] = c;
          adv = 1'b1;
        end else begin
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::word_kind(pre, len), beg, len, ln,
                                     stt_pkg::col_back(len, cl));
          n = n + 1'b1;
          pre = '0;
          do_start = 1'b1;
        end
      end
      stt_pkg::MODE_STR: begin
        if (c == 8'h00) begin
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::KIND_ERROR, beg, len, ln, cl);
          n = n + 1'b1;
          do_start = 1'b1;
        end else if ((q && c == "\"") || (!q && c == "'")) begin
          tk[n[0]] = stt_pkg::mk_tok(q ? stt_pkg::KIND_DQSTR : stt_pkg::KIND_SQSTR,
                                     beg, len, ln, stt_pkg::col_back(len, cl));
          n = n + 1'b1;
          adv = 1'b1;
          m = stt_pkg::MODE_IDLE;
        end else begin
          if (c == 8'h0a) begin
            ln = (ln != stt_pkg::LineMax) ? ln + 1'b1 : ln;
            cl = 16'd1;
          end
          adv = 1'b1;
        end
      end
      default: do_start = 1'b1;
    endcase

    if (adv) begin
      off = (off != stt_pkg::OffMax) ? off + 1'b1 : off;
      cl  = (cl != stt_pkg::ColMax) ? cl + 1'b1 : cl;
    end

    // byte seen between tokens
    if (do_start) begin
      m = stt_pkg::MODE_IDLE;
      adv = 1'b0;
      if (c == 8'h00) begin
        tk[n[0]] = stt_pkg::mk_tok(stt_pkg::KIND_EOF, off, '0, ln, cl);
        n = n + 1'b1;
        h = '0; off = '0; beg = '0; ln = fline_q; cl = fcol_q; pre = '0; q = 1'b0;
      end else if (c == " " || c == 8'h09) begin
        adv = 1'b1;
      end else if (c == 8'h0a) begin
        ln = (ln != stt_pkg::LineMax) ? ln + 1'b1 : ln;
        cl = '0;
        adv = 1'b1;
      end else begin
        beg = off;
        if (c == "/") begin
          adv = 1'b1; m = stt_pkg::MODE_SLASH;
        end else if (c == "&" || c == "|" || c == "!" || c == "=" || c == ">" ||
                     c == "<" || c == ":") begin
          h = c; adv = 1'b1; m = stt_pkg::MODE_HOLD;
        end else if (stt_pkg::single_kind(c) != stt_pkg::KIND_ERROR) begin
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::single_kind(c), beg, 24'd1, ln, cl);
          n = n + 1'b1;
          adv = 1'b1;
        end else if (c == "\"" || c == "'") begin
          off = (off != stt_pkg::OffMax) ? off + 1'b1 : off;
          cl  = (cl != stt_pkg::ColMax) ? cl + 1'b1 : cl;
          beg = off;
          q = (c == "\"");
          m = stt_pkg::MODE_STR;
        end else if (stt_pkg::is_numeral(c)) begin
          adv = 1'b1; m = stt_pkg::MODE_NUM;
        end else if (stt_pkg::is_letter(c)) begin
          pre = {56'h0, c}; adv = 1'b1; m = stt_pkg::MODE_WORD;
        end else begin
          off = (off != stt_pkg::OffMax) ? off + 1'b1 : off;
          cl  = (cl != stt_pkg::ColMax) ? cl + 1'b1 : cl;
          tk[n[0]] = stt_pkg::mk_tok(stt_pkg::KIND_ERROR, beg, off - beg, ln, cl);
          n = n + 1'b1;
        end
      end
      if (adv) begin
        off = (off != stt_pkg::OffMax) ? off + 1'b1 : off;
        cl  = (cl != stt_pkg::ColMax) ? cl + 1'b1 : cl;
      end
    end

    if (n == 2'd1) tk[0].last = 1'b1;
    if (n == 2'd2) tk[1].last = 1'b1;

    mode_d = mode_q; held_d = held_q; off_d = off_q; beg_d = beg_q; line_d = line_q;
    col_d = col_q; pre_d = pre_q; quote_d = quote_q;
    fline_d = fline_q; fcol_d = fcol_q;
    if (in_acc) begin
      mode_d = m; held_d = h; off_d = off; beg_d = beg; line_d = ln;
      col_d = cl; pre_d = pre; quote_d = q;
    end
    if (cfg_we) begin
      case (cfg_index_i)
        stt_pkg::CFG_FIRST_LINE: begin
          fline_d = cfg_data_i;
          if (fresh) line_d = cfg_data_i;
        end
        stt_pkg::CFG_FIRST_COLUMN: begin
          fcol_d = cfg_data_i[stt_pkg::ColBits-1:0];
          if (fresh) col_d = cfg_data_i[stt_pkg::ColBits-1:0];
        end
        default: ;
      endcase
    end
    ntok = in_acc ? n : 2'd0;
    tk0 = tk[0];
    tk1 = tk[1];
  end

  assign push_o.count = ntok;
  assign push_o.tok0  = tk0;
  assign push_o.tok1  = tk1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= stt_pkg::MODE_IDLE;
      held_q  <= '0;
      off_q   <= '0;
      beg_q   <= '0;
      line_q  <= 24'd1;
      col_q   <= 16'd1;
      fline_q <= 24'd1;
      fcol_q  <= 16'd1;
      pre_q   <= '0;
      quote_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      held_q  <= held_d;
      off_q   <= off_d;
      beg_q   <= beg_d;
      line_q  <= line_d;
      col_q   <= col_d;
      fline_q <= fline_d;
      fcol_q  <= fcol_d;
      pre_q   <= pre_d;
      quote_q <= quote_d;
    end
  end

endmodule

@@ hdl/stt_queue.sv @@
module stt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  stt_pkg::push_t  push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output stt_pkg::token_t head_o
);

  stt_pkg::token_t                mem_q [stt_pkg::QueueDepth];
  logic [stt_pkg::QPtrBits-1:0]   rd_q, rd_d, wr_q, wr_d;
  logic [stt_pkg::QCntBits-1:0]   cnt_q, cnt_d;
  logic                           pop;

  // room for the two words a byte may give
  assign room_o      = cnt_q <= stt_pkg::QCntBits'(stt_pkg::QueueDepth - 2);
  assign out_valid_o = cnt_q != '0;
  assign head_o      = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    wr_d  = wr_q + stt_pkg::QPtrBits'(push_i.count);
    cnt_d = cnt_q + stt_pkg::QCntBits'(push_i.count) - stt_pkg::QCntBits'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.tok0;
    if (push_i.count == 2'd2) mem_q[wr_q + 1'b1] <= push_i.tok1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= stt_pkg::QCntBits'(stt_pkg::QueueDepth)) else $error("queue overfilled");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> room_o) else $error("push without room");

  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && push_i.count == 2'd0) |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("pop lost");

  a_no_pair_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count == 2'd2) |-> (!push_i.tok0.last && push_i.tok1.last))
    else $error("run end mark misplaced");

endmodule

@@ hdl/source_text_tokenizer_unit.sv @@
// source text tokenizer
// input channel: one source byte per word on char_code_i (in_valid_i/in_stall_o);
//   a zero byte ends the source, flushes any open token, gives an eof token
//   and rearms the offset, line and column counters
// output channel: one token per word (out_valid_o/out_stall_i) with kind,
//   offset, length, line, column and last_of_run marking the final token of
//   the byte that caused it
// configuration: cfg_index_i 0 sets the first line, 1 the first column; a
//   write counts at the next rearm, or at once before any byte is taken
// the scanner takes one byte a cycle while the queue has room and classifies it
//   in that same cycle; tokens go to a four-word queue whose head drives the
//   outputs, so a token is written into the queue before it is offered
// throughput: one byte per cycle while the queue has room for two words; a
//   byte that both closes a token and makes one gives two words, which the
//   single output port drains one word at a time
// when the receiver stalls the head word holds and the queue fills; once it
//   lacks room for two words in_stall_o rises; the scanner keeps its state meanwhile
// reset: offset cleared, line, column, first line and first column back to one, queue empty
module source_text_tokenizer_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   char_code_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [stt_pkg::KindBits-1:0]   token_kind_o,
  output logic [stt_pkg::OffsetBits-1:0] token_offset_o,
  output logic [stt_pkg::OffsetBits-1:0] token_length_o,
  output logic [stt_pkg::LineBits-1:0]   token_line_o,
  output logic [stt_pkg::ColBits-1:0]    token_column_o,
  output logic                         last_of_run_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [stt_pkg::LineBits-1:0]   cfg_data_i
);

  stt_pkg::push_t  push;
  stt_pkg::token_t head;
  logic            room;

  // front: byte classification and token building
  stt_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .room_i      (room),
    .push_o      (push)
  );

  // back: token queue, head word is the output register
  stt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign token_kind_o   = head.kind;
  assign token_offset_o = head.offset;
  assign token_length_o = head.length;
  assign token_line_o   = head.line;
  assign token_column_o = head.column;
  assign last_of_run_o  = head.last;

endmodule
